// File: hw/rtl/pfc_pkg.sv
// Shared types, constants and the CRC byte update for the packet framer.
package pfc_pkg;

    localparam int unsigned POS_W = 6;
    localparam int unsigned HDR_IDX_W = 4;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned CFG_AW = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST = 4'd15;

    localparam logic [REG_IDX_W-1:0] REG_SENDER_ID = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RECEIVER_ID = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PACKET_NUMBER = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MESSAGE_LENGTH = 2'd3;

    localparam logic [31:0] MESSAGE_LENGTH_RESET = 32'd46;

    typedef struct packed {
        logic [31:0] sender_id;
        logic [31:0] receiver_id;
        logic [31:0] packet_number;
        logic [31:0] message_length;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_START,
        ST_HEADER,
        ST_BODY,
        ST_CRC_HI,
        ST_CRC_LO
    } seq_state_t;

    // CRC-16/CCITT-FALSE update by one byte, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15])
            begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// File: hw/rtl/pfc_in_if.sv
// Input channel carrying one payload byte per transfer.
interface pfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;

    modport source (output valid, output payload_byte, input ready);
    modport sink (input valid, input payload_byte, output ready);
endinterface

// File: hw/rtl/pfc_out_if.sv
// Output channel carrying one frame byte and its markers per transfer.
interface pfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, output frame_byte, output frame_end, output run_last,
                    input ready);
    modport sink (input valid, input frame_byte, input frame_end, input run_last,
                  output ready);
endinterface

// File: hw/rtl/pfc_regs.sv
// APB configuration registers holding the four header words.
module pfc_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pfc_pkg::cfg_t              cfg
);

    pfc_pkg::cfg_t                   cfg_reg;
    logic [pfc_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[pfc_pkg::CFG_AW-1:2];
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sender_id <= '0;
            cfg_reg.receiver_id <= '0;
            cfg_reg.packet_number <= '0;
            cfg_reg.message_length <= pfc_pkg::MESSAGE_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pfc_pkg::REG_SENDER_ID:      cfg_reg.sender_id <= pwdata;
                pfc_pkg::REG_RECEIVER_ID:    cfg_reg.receiver_id <= pwdata;
                pfc_pkg::REG_PACKET_NUMBER:  cfg_reg.packet_number <= pwdata;
                pfc_pkg::REG_MESSAGE_LENGTH: cfg_reg.message_length <= pwdata;
                default:                     cfg_reg.sender_id <= cfg_reg.sender_id;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pfc_pkg::REG_SENDER_ID:      prdata = cfg_reg.sender_id;
            pfc_pkg::REG_RECEIVER_ID:    prdata = cfg_reg.receiver_id;
            pfc_pkg::REG_PACKET_NUMBER:  prdata = cfg_reg.packet_number;
            pfc_pkg::REG_MESSAGE_LENGTH: prdata = cfg_reg.message_length;
            default:                     prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/pfc_seq.sv
// Input register, frame sequencer with running CRC, and output register.
module pfc_seq
#(
    parameter int unsigned PAYLOAD_BYTES = 46
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  pfc_pkg::cfg_t   cfg,
    pfc_in_if.sink          in_ch,
    pfc_out_if.source       out_ch
);

    localparam int unsigned FRAME_LEN = (PAYLOAD_BYTES < 2) ? 2 :
                                        ((PAYLOAD_BYTES > 63) ? 63 : PAYLOAD_BYTES);
    localparam logic [pfc_pkg::POS_W-1:0] LAST_POS = pfc_pkg::POS_W'(FRAME_LEN - 1);

    pfc_pkg::seq_state_t              state_reg, state_next;
    logic                             item_valid_reg;
    logic [7:0]                       item_byte_reg;
    logic [pfc_pkg::POS_W-1:0]        pos_reg;
    logic [pfc_pkg::HDR_IDX_W-1:0]    hdr_idx_reg;
    logic [15:0]                      crc_reg;
    logic                             out_valid_reg;
    logic [7:0]                       out_byte_reg;
    logic                             out_end_reg;
    logic                             out_last_reg;

    logic                             emit_ok;
    logic                             item_last;
    logic                             frame_start;
    logic [pfc_pkg::HDR_IDX_W-1:0]    hdr_sel;
    logic [31:0]                      hdr_word;
    logic [7:0]                       hdr_byte;

    logic                             emit;
    logic                             consume;
    logic                             feed;
    logic                             feed_from_init;
    logic [7:0]                       emit_byte;
    logic                             emit_end;
    logic                             emit_last;
    logic [15:0]                      crc_base;

    assign emit_ok = !out_valid_reg || out_ch.ready;
    assign item_last = (pos_reg == LAST_POS);
    assign frame_start = (pos_reg == '0);
    assign in_ch.ready = !item_valid_reg || consume;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.frame_byte = out_byte_reg;
    assign out_ch.frame_end = out_end_reg;
    assign out_ch.run_last = out_last_reg;

    // Header byte 0 goes out in the start state; the rest come from the index.
    assign hdr_sel = (state_reg == pfc_pkg::ST_START) ? '0 : hdr_idx_reg;

    always_comb
    begin
        case (hdr_sel[3:2])
            pfc_pkg::REG_SENDER_ID:      hdr_word = cfg.sender_id;
            pfc_pkg::REG_RECEIVER_ID:    hdr_word = cfg.receiver_id;
            pfc_pkg::REG_PACKET_NUMBER:  hdr_word = cfg.packet_number;
            pfc_pkg::REG_MESSAGE_LENGTH: hdr_word = cfg.message_length;
            default:                     hdr_word = '0;
        endcase
    end

    always_comb
    begin
        case (hdr_sel[1:0])
            2'd0:    hdr_byte = hdr_word[31:24];
            2'd1:    hdr_byte = hdr_word[23:16];
            2'd2:    hdr_byte = hdr_word[15:8];
            2'd3:    hdr_byte = hdr_word[7:0];
            default: hdr_byte = hdr_word[7:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfc_pkg::ST_START:
            begin
                if (item_valid_reg && emit_ok)
                begin
                    if (frame_start)
                    begin
                        state_next = pfc_pkg::ST_HEADER;
                    end
                    else if (item_last)
                    begin
                        state_next = pfc_pkg::ST_CRC_HI;
                    end
                end
            end
            pfc_pkg::ST_HEADER:
            begin
                if (emit_ok && (hdr_idx_reg == pfc_pkg::HDR_LAST))
                begin
                    state_next = pfc_pkg::ST_BODY;
                end
            end
            pfc_pkg::ST_BODY:
            begin
                if (emit_ok)
                begin
                    state_next = item_last ? pfc_pkg::ST_CRC_HI : pfc_pkg::ST_START;
                end
            end
            pfc_pkg::ST_CRC_HI:
            begin
                if (emit_ok)
                begin
                    state_next = pfc_pkg::ST_CRC_LO;
                end
            end
            pfc_pkg::ST_CRC_LO:
            begin
                if (emit_ok)
                begin
                    state_next = pfc_pkg::ST_START;
                end
            end
            default:
            begin
                state_next = pfc_pkg::ST_START;
            end
        endcase
    end

    always_comb
    begin
        emit = 1'b0;
        consume = 1'b0;
        feed = 1'b0;
        feed_from_init = 1'b0;
        emit_byte = item_byte_reg;
        emit_end = 1'b0;
        emit_last = 1'b0;
        case (state_reg)
            pfc_pkg::ST_START:
            begin
                if (item_valid_reg)
                begin
                    emit = emit_ok;
                    feed = emit_ok;
                    if (frame_start)
                    begin
                        emit_byte = hdr_byte;
                        feed_from_init = 1'b1;
                    end
                    else
                    begin
                        consume = emit_ok;
                        emit_last = !item_last;
                    end
                end
            end
            pfc_pkg::ST_HEADER:
            begin
                emit = emit_ok;
                feed = emit_ok;
                emit_byte = hdr_byte;
            end
            pfc_pkg::ST_BODY:
            begin
                emit = emit_ok;
                feed = emit_ok;
                consume = emit_ok;
                emit_last = !item_last;
            end
            pfc_pkg::ST_CRC_HI:
            begin
                emit = emit_ok;
                emit_byte = crc_reg[15:8];
            end
            pfc_pkg::ST_CRC_LO:
            begin
                emit = emit_ok;
                emit_byte = crc_reg[7:0];
                emit_end = 1'b1;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign crc_base = feed_from_init ? pfc_pkg::CRC_INIT : crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfc_pkg::ST_START;
            item_valid_reg <= 1'b0;
            pos_reg <= '0;
            hdr_idx_reg <= '0;
            crc_reg <= pfc_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_ch.valid && in_ch.ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                item_valid_reg <= 1'b0;
            end

            if (consume)
            begin
                pos_reg <= item_last ? '0 : pos_reg + 1'b1;
            end

            if (emit && (state_reg == pfc_pkg::ST_START) && frame_start)
            begin
                hdr_idx_reg <= pfc_pkg::HDR_IDX_W'(1);
            end
            else if (emit && (state_reg == pfc_pkg::ST_HEADER))
            begin
                hdr_idx_reg <= hdr_idx_reg + 1'b1;
            end

            if (feed)
            begin
                crc_reg <= pfc_pkg::crc_feed(crc_base, emit_byte);
            end
            else if (emit && (state_reg == pfc_pkg::ST_CRC_LO))
            begin
                crc_reg <= pfc_pkg::CRC_INIT;
            end

            if (emit_ok)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_byte_reg <= in_ch.payload_byte;
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_end_reg <= emit_end;
            out_last_reg <= emit_last;
        end
    end

endmodule

// File: hw/rtl/packet_framer_crc16_top.sv
// Top level of the packet framer with CRC-16 trailer.
//
// Payload bytes arrive one per transfer on in_ch; frame bytes leave one per
// transfer on out_ch with frame_end on the low CRC byte and run_last on the
// final output byte caused by each input byte. The APB port sets the four
// header words; it should be written only while no frame byte is pending.
// A frame is 16 header bytes, the payload bytes and two CRC bytes.
// Every output byte passes through one sequencer step, so the block emits
// at most one byte per cycle: the first payload byte of a frame is preceded
// by the 16 header bytes, a middle byte gives only itself, and the last
// byte is followed by the CRC high and low bytes.
// The first output byte caused by an input transfer passes through the input
// register, then the output register, and leaves when the receiver takes it.
// A new payload byte is taken while the previous one is being sent out.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits; the input register then fills and in_ch.ready drops.
// Reset empties both registers, clears the byte position, loads the CRC
// with 0xFFFF and sets message_length to 46, the other header words to 0.
module packet_framer_crc16_top
#(
    parameter int unsigned PAYLOAD_BYTES = 46
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    pfc_in_if.sink                     in_ch,
    pfc_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    pfc_pkg::cfg_t cfg;

    pfc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfc_seq
    #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    )
    u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule
